>>> rtl/rhd_pkg.sv
// Package for the record header deframer: widths, status codes, limits.
package rhd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned VER_W = 16;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned HDR_IDX_W = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 32;

  localparam int unsigned MAX_BODY = 18432;
  localparam int unsigned EXTRA_ALLOWANCE = 16384;
  // one spare bit so the sum never wraps
  localparam int unsigned LIMIT_W = LEN_W + 1;
  localparam logic [LIMIT_W-1:0] LIMIT_BASE = LIMIT_W'(MAX_BODY);
  localparam logic [LIMIT_W-1:0] LIMIT_BIG = LIMIT_W'(MAX_BODY + EXTRA_ALLOWANCE);

  localparam logic [BYTE_W-1:0] MAJOR_OK = 8'd3;
  localparam logic [VER_W-1:0] EXP_VER_RESET = 16'd768;

  localparam logic [STATUS_W-1:0] ST_PAYLOAD = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_VERSION = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_MAJOR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_EXP_VERSION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_BUFFER = 1'd1;

  localparam logic [HDR_IDX_W-1:0] HDR_TYPE = 3'd0;
  localparam logic [HDR_IDX_W-1:0] HDR_VER_HI = 3'd1;
  localparam logic [HDR_IDX_W-1:0] HDR_VER_LO = 3'd2;
  localparam logic [HDR_IDX_W-1:0] HDR_LEN_HI = 3'd3;
  localparam logic [HDR_IDX_W-1:0] HDR_LEN_LO = 3'd4;

  typedef struct packed {
    logic [VER_W-1:0] received_version;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] record_type;
  } out_data_t;

endpackage

>>> rtl/record_header_deframer_top.sv
// Record header deframer: header capture, checks and body byte streaming.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+------------------------------------
//   in_     | in  | in_tvalid / in_tready  | in_tdata: rx_byte
//   out_    | out | out_tvalid / out_tready| tdata: type, byte, version; tuser:
//           |     |                        | status; tlast: last_of_record
//   cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One byte is taken every cycle while in_tready is high and its result is
// registered. Header bytes give no word but the error word of a failed header;
// empty records give none. Input is blocked only while the output register is
// full and out_tready is low. After an error word every byte is taken and
// dropped until reset. Reset is synchronous; config writes are always ready.
module record_header_deframer_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rhd_pkg::BYTE_W-1:0]        in_tdata,   // [7:0] rx_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] record_type, [15:8] payload_byte, [31:16] received_version
  output logic [rhd_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [rhd_pkg::STATUS_W-1:0]      out_tuser,  // [1:0] status
  output logic                              out_tlast,  // last_of_record
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rhd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rhd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rhd_pkg::*;

  logic [VER_W-1:0]     exp_version_r;
  logic                 big_buffer_r;

  logic [HDR_IDX_W-1:0] hdr_idx_r, hdr_idx_nxt;
  logic                 in_body_r, in_body_nxt;
  logic [BYTE_W-1:0]    held_type_r, held_type_nxt;
  logic [VER_W-1:0]     held_ver_r, held_ver_nxt;
  logic [LEN_W-1:0]     body_rem_r, body_rem_nxt;
  logic                 first_rec_r, first_rec_nxt;
  logic                 halted_r, halted_nxt;

  logic                 out_valid_r;
  out_data_t            out_data_r, out_data_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 emit;

  logic                 in_acc;
  logic [LEN_W-1:0]     length;
  logic [LIMIT_W-1:0]   limit;
  logic [STATUS_W-1:0]  hdr_status;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // header checks on the fifth byte, in priority order
  assign length = {body_rem_r[LEN_W-1:BYTE_W], in_tdata};
  assign limit  = big_buffer_r ? LIMIT_BIG : LIMIT_BASE;

  always_comb begin
    hdr_status = ST_PAYLOAD;
    if (!first_rec_r && (held_ver_r != exp_version_r)) begin
      hdr_status = ST_BAD_VERSION;
    end else if (held_ver_r[VER_W-1:BYTE_W] != MAJOR_OK) begin
      hdr_status = ST_BAD_MAJOR;
    end else if ({1'b0, length} > limit) begin
      hdr_status = ST_TOO_LONG;
    end
  end

  always_comb begin
    hdr_idx_nxt    = hdr_idx_r;
    in_body_nxt    = in_body_r;
    held_type_nxt  = held_type_r;
    held_ver_nxt   = held_ver_r;
    body_rem_nxt   = body_rem_r;
    first_rec_nxt  = first_rec_r;
    halted_nxt     = halted_r;
    emit           = 1'b0;
    out_data_nxt   = '{received_version: held_ver_r, payload_byte: in_tdata,
                       record_type: held_type_r};
    out_status_nxt = ST_PAYLOAD;
    out_last_nxt   = 1'b0;

    if (in_acc && !halted_r) begin
      if (in_body_r) begin
        emit = 1'b1;
        // remaining count is at least one while in the body
        if (body_rem_r <= LEN_W'(1)) begin
          out_last_nxt = 1'b1;
          body_rem_nxt = '0;
          in_body_nxt  = 1'b0;
          hdr_idx_nxt  = HDR_TYPE;
        end else begin
          body_rem_nxt = body_rem_r - LEN_W'(1);
        end
      end else begin
        case (hdr_idx_r)
          HDR_TYPE: begin
            held_type_nxt = in_tdata;
            hdr_idx_nxt   = HDR_VER_HI;
          end
          HDR_VER_HI: begin
            held_ver_nxt = {in_tdata, {BYTE_W{1'b0}}};
            hdr_idx_nxt  = HDR_VER_LO;
          end
          HDR_VER_LO: begin
            held_ver_nxt = {held_ver_r[VER_W-1:BYTE_W], in_tdata};
            hdr_idx_nxt  = HDR_LEN_HI;
          end
          HDR_LEN_HI: begin
            body_rem_nxt = {in_tdata, {BYTE_W{1'b0}}};
            hdr_idx_nxt  = HDR_LEN_LO;
          end
          default: begin
            body_rem_nxt  = length;
            hdr_idx_nxt   = HDR_TYPE;
            first_rec_nxt = 1'b0;
            if (hdr_status != ST_PAYLOAD) begin
              emit           = 1'b1;
              halted_nxt     = 1'b1;
              out_status_nxt = hdr_status;
              out_data_nxt.payload_byte = '0;
            end else begin
              in_body_nxt = (length != '0);
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_version_r <= EXP_VER_RESET;
      big_buffer_r  <= 1'b0;
      hdr_idx_r     <= HDR_TYPE;
      in_body_r     <= 1'b0;
      held_type_r   <= '0;
      held_ver_r    <= '0;
      body_rem_r    <= '0;
      first_rec_r   <= 1'b1;
      halted_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EXP_VERSION: exp_version_r <= cfg_data;
          REG_BIG_BUFFER:  big_buffer_r  <= cfg_data[0];
          default: ;
        endcase
      end
      hdr_idx_r   <= hdr_idx_nxt;
      in_body_r   <= in_body_nxt;
      held_type_r <= held_type_nxt;
      held_ver_r  <= held_ver_nxt;
      body_rem_r  <= body_rem_nxt;
      first_rec_r <= first_rec_nxt;
      halted_r    <= halted_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output word payload, loaded only when a new word is produced
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

endmodule

>>> sim/tb_record_header_deframer_top.sv
// Self-checking testbench for record_header_deframer_top: header capture, checks, body stream.
module tb_record_header_deframer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rhd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned N_DIR = 9;
  localparam int unsigned PHASE_BYTES = 150;
  localparam int unsigned DROP_BYTES = 20;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   rtype;
    logic [BYTE_W-1:0]   pbyte;
    logic                last;
    logic [VER_W-1:0]    ver;
  } deframed_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rtype;
    logic [VER_W-1:0]  ver;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] fill;
    logic              rnd_body;
    logic              typed;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state and register copies
  logic [HDR_IDX_W-1:0] hdr_pos = HDR_TYPE;
  logic                 in_payload = 1'b0;
  logic [BYTE_W-1:0]    cur_type = '0;
  logic [VER_W-1:0]     cur_ver = '0;
  logic [LEN_W-1:0]     bytes_left = '0;
  logic                 first_pending = 1'b1;
  logic                 halted_seen = 1'b0;
  logic [VER_W-1:0]     exp_ver_reg = EXP_VER_RESET;
  logic                 big_buf_reg = 1'b0;

  deframed_t   expected_words[$];
  dir_row_t    dir_rows[N_DIR];
  int unsigned errors = 0;
  int unsigned n_words = 0;
  int unsigned n_bytes = 0;
  int unsigned n_records = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          in_quiet = 1'b0;
  bit          out_quiet = 1'b0;

  record_header_deframer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 2);
    return $urandom_range(3, 12);
  endfunction

  function automatic logic [LEN_W-1:0] body_limit();
    return big_buf_reg ? LEN_W'(MAX_BODY + EXTRA_ALLOWANCE) : LEN_W'(MAX_BODY);
  endfunction

  // One received byte through the deframer; returns 1 when it yields a word.
  function automatic bit deframe_step(input logic [BYTE_W-1:0] b, output deframed_t w);
    logic [STATUS_W-1:0] st;
    w = '0;
    if (halted_seen) return 1'b0;
    if (in_payload) begin
      w.status = ST_PAYLOAD;
      w.rtype = cur_type;
      w.pbyte = b;
      w.last = (bytes_left <= LEN_W'(1));
      w.ver = cur_ver;
      if (w.last) begin
        bytes_left = '0;
        in_payload = 1'b0;
        hdr_pos = HDR_TYPE;
      end else begin
        bytes_left = bytes_left - LEN_W'(1);
      end
      return 1'b1;
    end
    case (hdr_pos)
      HDR_TYPE: begin
        cur_type = b;
        hdr_pos = HDR_VER_HI;
        return 1'b0;
      end
      HDR_VER_HI: begin
        cur_ver = {b, 8'h00};
        hdr_pos = HDR_VER_LO;
        return 1'b0;
      end
      HDR_VER_LO: begin
        cur_ver[7:0] = b;
        hdr_pos = HDR_LEN_HI;
        return 1'b0;
      end
      HDR_LEN_HI: begin
        bytes_left = {b, 8'h00};
        hdr_pos = HDR_LEN_LO;
        return 1'b0;
      end
      default: ;
    endcase
    bytes_left[7:0] = b;
    hdr_pos = HDR_TYPE;
    st = ST_PAYLOAD;
    // version compare is waived on the first header only
    if (first_pending) first_pending = 1'b0;
    else if (cur_ver != exp_ver_reg) st = ST_BAD_VERSION;
    if (st == ST_PAYLOAD && cur_ver[15:8] != MAJOR_OK) st = ST_BAD_MAJOR;
    if (st == ST_PAYLOAD && bytes_left > body_limit()) st = ST_TOO_LONG;
    if (st != ST_PAYLOAD) begin
      halted_seen = 1'b1;
      w.status = st;
      w.rtype = cur_type;
      w.ver = cur_ver;
      return 1'b1;
    end
    in_payload = (bytes_left != '0);
    return 1'b0;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed, input deframed_t typed_w);
    int unsigned gap;
    deframed_t w;
    gap = pick_gap(in_quiet);
    if ($urandom_range(0, 199) == 0) in_quiet = !in_quiet;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    n_bytes++;
    if (deframe_step(b, w)) expected_words.push_back(typed ? typed_w : w);
  endtask

  // typed: the record's final word is given here instead of by the predictor
  task automatic send_record(input logic [BYTE_W-1:0] rtype, input logic [VER_W-1:0] ver,
                             input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] fill,
                             input bit rnd_body, input bit typed,
                             input logic [STATUS_W-1:0] end_status);
    deframed_t tw;
    logic [4:0][BYTE_W-1:0] hdr;
    tw = '0;
    tw.status = end_status;
    tw.rtype = rtype;
    tw.ver = ver;
    hdr = {rtype, ver, len};
    for (int i = 4; i >= 0; i--)
      send_byte(hdr[i], typed && i == 0 && end_status != ST_PAYLOAD, tw);
    n_records++;
    if (end_status != ST_PAYLOAD) return;
    tw.pbyte = fill;
    tw.last = 1'b1;
    for (int k = 0; k < int'(len); k++)
      send_byte(rnd_body ? BYTE_W'($urandom) : fill, typed && k == int'(len) - 1, tw);
  endtask

  task automatic rand_record();
    logic [LEN_W-1:0] len;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) len = '0;
    else if (r < 30) len = LEN_W'(1);
    else if (r < 80) len = LEN_W'($urandom_range(2, 16));
    else if (r < 95) len = LEN_W'($urandom_range(17, 64));
    else len = LEN_W'($urandom_range(65, 400));
    send_record(BYTE_W'($urandom), exp_ver_reg, len, '0, 1'b1, 1'b0, ST_PAYLOAD);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_EXP_VERSION) exp_ver_reg = data;
    else big_buf_reg = data[0];
  endtask

  task automatic set_config(input logic [VER_W-1:0] ver, input logic [CFG_DATA_W-1:0] big);
    cfg_write(REG_EXP_VERSION, ver);
    cfg_write(REG_BIG_BUFFER, big);
    cfg_valid <= 1'b0;
  endtask

  // header bytes leave nothing pending, so the wait runs on past the last word
  task automatic wait_idle();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // receiver side: random stalls, with quiet stretches
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 4) == 0) stall_left = pick_gap(out_quiet);
    end
    if ($urandom_range(0, 299) == 0) out_quiet = !out_quiet;
  end

  always @(posedge clk) begin
    out_data_t od;
    deframed_t want;
    if (rst_n && out_tvalid && out_tready) begin
      od = out_tdata;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual status %0d data %h last %b",
                 $time, out_tuser, out_tdata, out_tlast);
        errors++;
      end else begin
        want = expected_words.pop_front();
        n_words++;
        check_field("status", want.status, out_tuser);
        check_field("record_type", want.rtype, od.record_type);
        check_field("payload_byte", want.pbyte, od.payload_byte);
        check_field("last_of_record", want.last, out_tlast);
        check_field("received_version", want.ver, od.received_version);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, expected_words.size());
      $display("tb_record_header_deframer_top: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned phase_start;
    logic [STATUS_W-1:0] err_st;
    logic [VER_W-1:0] ev;
    logic [VER_W-1:0] rv;
    logic [LEN_W-1:0] rl;
    logic [BYTE_W-1:0] maj;
    logic [CFG_DATA_W-1:0] bigd;
    deframed_t none;
    none = '0;
    // rtype, ver, len, fill, rnd_body, typed
    dir_rows[0] = '{8'h16, 16'h03FF, 16'd1, 8'hAA, 1'b0, 1'b1}; // first header, version waived
    dir_rows[1] = '{8'h00, 16'h0300, 16'd0, 8'h00, 1'b0, 1'b0}; // empty record
    dir_rows[2] = '{8'hFF, 16'h0300, 16'd1, 8'hFF, 1'b0, 1'b1};
    dir_rows[3] = '{8'h17, 16'h0300, 16'd2, 8'h00, 1'b0, 1'b1};
    dir_rows[4] = '{8'h15, 16'h0300, 16'd256, 8'h00, 1'b1, 1'b0};
    dir_rows[5] = '{8'h14, 16'h0300, 16'd255, 8'h55, 1'b0, 1'b1};
    dir_rows[6] = '{8'h80, 16'h0300, 16'd0, 8'h00, 1'b0, 1'b0};
    dir_rows[7] = '{8'h01, 16'h0300, 16'd3, 8'h80, 1'b0, 1'b1};
    dir_rows[8] = '{8'h7F, 16'h0300, 16'd17, 8'h00, 1'b1, 1'b0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part runs on the reset register values
    for (int r = 0; r < N_DIR; r++)
      send_record(dir_rows[r].rtype, dir_rows[r].ver, dir_rows[r].len, dir_rows[r].fill,
                  dir_rows[r].rnd_body, dir_rows[r].typed, ST_PAYLOAD);
    in_tvalid <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0: set_config(16'h0300, {15'($urandom), 1'b1});
        1: set_config({MAJOR_OK, 8'($urandom)}, {15'($urandom), 1'b0});
        2: set_config({MAJOR_OK, 8'hFF}, 16'hFFFF);
        default: set_config({MAJOR_OK, 8'h01}, 16'hFFFE);
      endcase
      phase_start = n_bytes;
      while (n_bytes - phase_start < PHASE_BYTES) rand_record();
      in_tvalid <= 1'b0;
    end

    // fatal header: one error word, then everything is dropped
    wait_idle();
    cfg_write(REG_EXP_VERSION, 16'hFFFF);
    cfg_write(REG_EXP_VERSION, 16'h0000);
    bigd = 16'($urandom);
    rl = 16'($urandom);
    case ($urandom_range(0, 2))
      0: begin
        err_st = ST_BAD_VERSION;
        ev = 16'($urandom);
        rv = ev ^ 16'($urandom_range(1, 65535));
      end
      1: begin
        err_st = ST_BAD_MAJOR;
        case ($urandom_range(0, 2))
          0: maj = 8'h00;
          1: maj = 8'hFF;
          default: do maj = 8'($urandom); while (maj == MAJOR_OK);
        endcase
        ev = {maj, 8'($urandom)};
        rv = ev;
      end
      default: begin
        err_st = ST_TOO_LONG;
        ev = {MAJOR_OK, 8'($urandom)};
        rv = ev;
      end
    endcase
    set_config(ev, bigd);
    if (err_st == ST_TOO_LONG) begin
      case ($urandom_range(0, 2))
        0: rl = body_limit() + LEN_W'(1);
        1: rl = 16'hFFFF;
        default: rl = LEN_W'($urandom_range(int'(body_limit()) + 1, 65535));
      endcase
    end
    send_record(8'($urandom), rv, rl, '0, 1'b0, 1'b1, err_st);
    repeat (DROP_BYTES) send_byte(8'($urandom), 1'b0, none);
    in_tvalid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_words.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, expected_words.size());
      errors++;
    end
    $display("Sent %0d records (%0d bytes) over 6 register settings; %0d words checked.",
             n_records, n_bytes, n_words);
    $display("Closed on a fatal header with status %0d and %0d bytes dropped after it.",
             err_st, DROP_BYTES);
    if (errors == 0) $display("tb_record_header_deframer_top: PASS");
    else $display("tb_record_header_deframer_top: FAIL");
    $finish;
  end

endmodule
